// ----- rtl/reversal_range_bar_builder_top_defines.svh -----
// ============================================================================
// reversal_range_bar_builder_top_defines.svh
// Assertion macros used by the bar engine (rrb_back).
// ============================================================================
`ifndef REVERSAL_RANGE_BAR_BUILDER_TOP_DEFINES_SVH
`define REVERSAL_RANGE_BAR_BUILDER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RRB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrb assertion failed");

// next-cycle implication, disabled while in reset
`define RRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrb assertion failed");

`endif

// ----- rtl/rrb_pkg.sv -----
// ============================================================================
// rrb_pkg
// Types, constants and helpers for the reversal range bar builder.
// ============================================================================
package rrb_pkg;

    localparam int TIME_W  = 48;
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 32;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 16;
    localparam int SRC_W   = 2;
    localparam int IDX_W   = 2;
    localparam int THR_W   = CFG_W + CFG_W + 1;

    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PRICE_SOURCE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_BAR_SIZE      = 2'd1;
    localparam logic [IDX_W-1:0] REG_REVERSAL_SIZE = 2'd2;
    localparam logic [IDX_W-1:0] REG_TICK_SIZE     = 2'd3;

    // price source codes
    localparam logic [SRC_W-1:0] SRC_LAST = 2'd0;
    localparam logic [SRC_W-1:0] SRC_MID  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_BID  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_ASK  = 2'd3;

    // armed reversal direction, two's complement
    localparam logic signed [1:0] ARM_NONE = 2'sb00;
    localparam logic signed [1:0] ARM_UP   = 2'sb01;
    localparam logic signed [1:0] ARM_DOWN = 2'sb11;

    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
    } item_t;

    typedef struct packed {
        logic [THR_W-1:0] rev;   // (reversal_size+1)*tick_size
        logic [THR_W-1:0] arm;   // bar_size*tick_size
        logic [THR_W-1:0] ext;   // (bar_size+1)*tick_size
    } thr_t;

    // a - b >= thr, false when a < b
    function automatic logic reaches(input logic [PRICE_W-1:0] a,
                                     input logic [PRICE_W-1:0] b,
                                     input logic [THR_W-1:0]   thr);
        logic [PRICE_W-1:0] d;
        d = a - b;
        return (a >= b) && ({{(THR_W-PRICE_W){1'b0}}, d} >= thr);
    endfunction

endpackage

// ----- rtl/reversal_range_bar_builder_top.sv -----
// ============================================================================
// reversal_range_bar_builder_top
// Reversal range bar builder: market ticks in, one bar snapshot out per tick.
// ============================================================================
// The block takes one tick per clock while in_stall is low and returns exactly
// one result per tick, in order: the accepted and new_bar flags plus the bar
// as it stands after the tick. Sustained rate is one tick per cycle while the
// result side is not stalled, set by the bar engine, which applies a tick
// straight into its state registers (one timestamp compare, the threshold
// compares against the open/high/low, and the saturating volume add). A tick
// is written into a two-entry queue at the edge that accepts it, popped into
// the bar engine once its result slot is free or being taken, and from then on
// the engine's state registers present the result until it is taken. The input
// stalls only when that queue is full, so a waiting result does not stop new
// ticks until the queue fills. Config writes land in their register at once; the
// price thresholds derived from them, (reversal+1)*tick, bar*tick and
// (bar+1)*tick, settle on the following edge, so write config only while no
// tick is in flight.
// ============================================================================
module reversal_range_bar_builder_top
    import rrb_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH   // front-to-engine queue depth, 2 and up
)
(
    input  logic                clk,
    input  logic                rst_n,
    // config write port
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // tick input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [TIME_W-1:0]   tick_time,
    input  logic [PRICE_W-1:0]  last_price,
    input  logic [PRICE_W-1:0]  mid_price,
    input  logic [PRICE_W-1:0]  bid_price,
    input  logic [PRICE_W-1:0]  ask_price,
    input  logic [VOL_W-1:0]    tick_volume,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                accepted,
    output logic                new_bar,
    output logic [PRICE_W-1:0]  bar_open,
    output logic [PRICE_W-1:0]  bar_high,
    output logic [PRICE_W-1:0]  bar_low,
    output logic [PRICE_W-1:0]  bar_close,
    output logic [SUM_W-1:0]    bar_volume,
    output logic [TIME_W-1:0]   bar_start,
    output logic [TIME_W-1:0]   bar_duration,
    output logic signed [1:0]   reversal_dir
);

    item_t front_item;   // tick with the configured price picked
    thr_t  thr;          // precomputed distance thresholds
    item_t q_head;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    logic  push;

    // a transfer on the input writes straight into the queue
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    rrb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_time   (tick_time),
        .last_price  (last_price),
        .mid_price   (mid_price),
        .bid_price   (bid_price),
        .ask_price   (ask_price),
        .tick_volume (tick_volume),
        .item        (front_item),
        .thr         (thr)
    );

    rrb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // engine pops whenever its result slot is free or being taken
    rrb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .thr          (thr),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .accepted     (accepted),
        .new_bar      (new_bar),
        .bar_open     (bar_open),
        .bar_high     (bar_high),
        .bar_low      (bar_low),
        .bar_close    (bar_close),
        .bar_volume   (bar_volume),
        .bar_start    (bar_start),
        .bar_duration (bar_duration),
        .reversal_dir (reversal_dir)
    );

endmodule

// ----- rtl/rrb_front.sv -----
// ============================================================================
// rrb_front
// Config registers, threshold precompute and tick price selection.
// ============================================================================
module rrb_front
    import rrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [TIME_W-1:0]  tick_time,
    input  logic [PRICE_W-1:0] last_price,
    input  logic [PRICE_W-1:0] mid_price,
    input  logic [PRICE_W-1:0] bid_price,
    input  logic [PRICE_W-1:0] ask_price,
    input  logic [VOL_W-1:0]   tick_volume,
    output item_t              item,
    output thr_t               thr
);

    logic [SRC_W-1:0]   price_source_reg;
    logic [CFG_W-1:0]   bar_size_reg;
    logic [CFG_W-1:0]   reversal_size_reg;
    logic [CFG_W-1:0]   tick_size_reg;
    thr_t               thr_reg;
    thr_t               thr_next;
    logic [CFG_W:0]     rev_p1;
    logic [CFG_W:0]     bar_p1;
    logic [PRICE_W-1:0] price_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_source_reg  <= SRC_LAST;
            bar_size_reg      <= CFG_W'(1);
            reversal_size_reg <= CFG_W'(1);
            tick_size_reg     <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRICE_SOURCE:  price_source_reg  <= cfg_data[SRC_W-1:0];
                REG_BAR_SIZE:      bar_size_reg      <= cfg_data;
                REG_REVERSAL_SIZE: reversal_size_reg <= cfg_data;
                REG_TICK_SIZE:     tick_size_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // thresholds are registered, so they settle on the edge after a config write
    always_comb
    begin
        rev_p1       = {1'b0, reversal_size_reg} + (CFG_W+1)'(1);
        bar_p1       = {1'b0, bar_size_reg} + (CFG_W+1)'(1);
        thr_next.rev = THR_W'(rev_p1) * THR_W'(tick_size_reg);
        thr_next.arm = THR_W'(bar_size_reg) * THR_W'(tick_size_reg);
        thr_next.ext = THR_W'(bar_p1) * THR_W'(tick_size_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.rev <= THR_W'(2);
            thr_reg.arm <= THR_W'(1);
            thr_reg.ext <= THR_W'(2);
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    always_comb
    begin
        unique case (price_source_reg)
            SRC_LAST: price_sel = last_price;
            SRC_MID:  price_sel = mid_price;
            SRC_BID:  price_sel = bid_price;
            SRC_ASK:  price_sel = ask_price;
            default:  price_sel = last_price;
        endcase
    end

    assign item.tick_time = tick_time;
    assign item.price     = price_sel;
    assign item.volume    = tick_volume;
    assign thr            = thr_reg;

endmodule

// ----- rtl/rrb_queue.sv -----
// ============================================================================
// rrb_queue
// Small FIFO between the front and the bar engine.
// ============================================================================
module rrb_queue
    import rrb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH   // 2 and up
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output item_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

endmodule

// ----- rtl/rrb_back.sv -----
// ============================================================================
// rrb_back
// Bar engine: applies one queued tick per cycle unless stalled; holds results.
// ============================================================================
`include "reversal_range_bar_builder_top_defines.svh"

module rrb_back
    import rrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  item_t               q_head,
    output logic                q_pop,
    input  thr_t                thr,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                accepted,
    output logic                new_bar,
    output logic [PRICE_W-1:0]  bar_open,
    output logic [PRICE_W-1:0]  bar_high,
    output logic [PRICE_W-1:0]  bar_low,
    output logic [PRICE_W-1:0]  bar_close,
    output logic [SUM_W-1:0]    bar_volume,
    output logic [TIME_W-1:0]   bar_start,
    output logic [TIME_W-1:0]   bar_duration,
    output logic signed [1:0]   reversal_dir
);

    logic                have_bar_reg;
    logic [PRICE_W-1:0]  open_reg, high_reg, low_reg, close_reg;
    logic [SUM_W-1:0]    vol_reg;
    logic [TIME_W-1:0]   start_reg, last_reg;
    logic signed [1:0]   armed_reg;
    logic                out_valid_reg, accepted_reg, new_bar_reg;

    logic                have_bar_next;
    logic [PRICE_W-1:0]  open_next, high_next, low_next;
    logic [SUM_W-1:0]    vol_next;
    logic [TIME_W-1:0]   start_next;
    logic signed [1:0]   armed_next;

    logic [PRICE_W-1:0]  px;
    logic                newer, rev_closed, above, below, ext_hit, open_new;
    logic [SUM_W-1:0]    vol_base;
    logic [SUM_W:0]      vol_sum;
    logic                bar_flat;

    assign q_pop = q_valid && (!out_valid_reg || !out_stall);
    assign px    = q_head.price;
    assign newer = q_head.tick_time > last_reg;

    always_comb
    begin
        rev_closed = 1'b0;
        if (armed_reg == ARM_UP)
        begin
            rev_closed = reaches(px, low_reg, thr.rev);
        end
        else if (armed_reg == ARM_DOWN)
        begin
            rev_closed = reaches(high_reg, px, thr.rev);
        end

        above      = px > high_reg;
        below      = px < low_reg;
        armed_next = armed_reg;
        ext_hit    = 1'b0;
        // reversal close skips arming and extension
        if (have_bar_reg && !rev_closed)
        begin
            if (above)
            begin
                if (reaches(px, low_reg, thr.arm))
                begin
                    armed_next = ARM_DOWN;
                end
                ext_hit = reaches(px, open_reg, thr.ext);
            end
            else if (below)
            begin
                if (reaches(high_reg, px, thr.arm))
                begin
                    armed_next = ARM_UP;
                end
                ext_hit = reaches(open_reg, px, thr.ext);
            end
        end

        open_new      = !have_bar_reg || rev_closed || ext_hit;
        have_bar_next = 1'b1;
        open_next     = open_new ? px : open_reg;
        high_next     = (open_new || above) ? px : high_reg;
        low_next      = (open_new || below) ? px : low_reg;
        start_next    = open_new ? q_head.tick_time : start_reg;

        vol_base = open_new ? '0 : vol_reg;
        vol_sum  = {1'b0, vol_base} + (SUM_W+1)'(q_head.volume);
        vol_next = vol_sum[SUM_W] ? {SUM_W{1'b1}} : vol_sum[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_bar_reg <= 1'b0;
            open_reg     <= '0;
            high_reg     <= '0;
            low_reg      <= '0;
            close_reg    <= '0;
            vol_reg      <= '0;
            start_reg    <= '0;
            last_reg     <= '0;
            armed_reg    <= ARM_NONE;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            new_bar_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                accepted_reg  <= newer;
                new_bar_reg   <= newer && open_new;
                if (newer)
                begin
                    have_bar_reg <= have_bar_next;
                    open_reg     <= open_next;
                    high_reg     <= high_next;
                    low_reg      <= low_next;
                    close_reg    <= px;
                    vol_reg      <= vol_next;
                    start_reg    <= start_next;
                    last_reg     <= q_head.tick_time;
                    armed_reg    <= armed_next;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // the bar state registers double as the result register
    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign new_bar      = new_bar_reg;
    assign bar_open     = open_reg;
    assign bar_high     = high_reg;
    assign bar_low      = low_reg;
    assign bar_close    = close_reg;
    assign bar_volume   = vol_reg;
    assign bar_start    = start_reg;
    assign bar_duration = last_reg - start_reg;
    assign reversal_dir = armed_reg;

    // a freshly opened bar is a single price
    assign bar_flat = (open_reg == close_reg) && (high_reg == open_reg) && (low_reg == open_reg);

    `RRB_ASSERT_NEXT(a_pop_gives_result, clk, rst_n, q_pop, out_valid_reg)
    `RRB_ASSERT_SAME(a_new_bar_accepted, clk, rst_n, out_valid_reg && new_bar_reg, accepted_reg)
    `RRB_ASSERT_SAME(a_new_bar_flat, clk, rst_n, out_valid_reg && new_bar_reg, bar_flat)
    `RRB_ASSERT_SAME(a_high_over_low, clk, rst_n, out_valid_reg, high_reg >= low_reg)

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the reversal range bar builder
// Ticks are pushed through the valid/stall input channel. A behavioral bar
// tracker predicts one snapshot per tick, and each result transfer is
// compared field by field against the oldest prediction. A directed table
// runs first, then randomized price walks under many register settings, a
// short flat run at maximum volume, and a tail at the largest timestamp.
// ----------------------------------------------------------------------------
module tb_top;

    import rrb_pkg::*;

    localparam int     PER_PHASE    = 56;       // accepted ticks per random phase
    localparam int     N_PHASES     = 12;
    localparam int     HOLD_PHASE   = 4;        // phase that opens with a long hold-off
    localparam int     HOLD_CYCLES  = 80;
    localparam int     DRAIN_CYCLES = 6;        // idle edges after the last result
    localparam int     FLAT_TICKS   = 16;       // max-volume ticks on one flat bar
    localparam longint PX_MAX       = 64'hFFFF_FFFF;
    localparam longint LIMIT_NS     = 64'd24_000_000;

    // one market tick as driven on the input ports
    typedef struct packed {
        logic [TIME_W-1:0]  tick_time;
        logic [PRICE_W-1:0] last_price;
        logic [PRICE_W-1:0] mid_price;
        logic [PRICE_W-1:0] bid_price;
        logic [PRICE_W-1:0] ask_price;
        logic [VOL_W-1:0]   tick_volume;
    } quote_t;

    // bar snapshot as seen on the result ports
    typedef struct packed {
        logic                accepted;
        logic                new_bar;
        logic [PRICE_W-1:0]  bar_open;
        logic [PRICE_W-1:0]  bar_high;
        logic [PRICE_W-1:0]  bar_low;
        logic [PRICE_W-1:0]  bar_close;
        logic [SUM_W-1:0]    bar_volume;
        logic [TIME_W-1:0]   bar_start;
        logic [TIME_W-1:0]   bar_duration;
        logic signed [1:0]   reversal_dir;
    } snap_t;

    // one row of the directed table; typed rows carry a hand-written snapshot
    typedef struct packed {
        quote_t             q;
        logic [SRC_W-1:0]   src;
        logic               typed;
        snap_t              want;
    } drow_t;

    // DUT ports, every input known from time zero
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_W-1:0]    cfg_data    = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [TIME_W-1:0]   tick_time   = '0;
    logic [PRICE_W-1:0]  last_price  = '0;
    logic [PRICE_W-1:0]  mid_price   = '0;
    logic [PRICE_W-1:0]  bid_price   = '0;
    logic [PRICE_W-1:0]  ask_price   = '0;
    logic [VOL_W-1:0]    tick_volume = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic                accepted;
    logic                new_bar;
    logic [PRICE_W-1:0]  bar_open;
    logic [PRICE_W-1:0]  bar_high;
    logic [PRICE_W-1:0]  bar_low;
    logic [PRICE_W-1:0]  bar_close;
    logic [SUM_W-1:0]    bar_volume;
    logic [TIME_W-1:0]   bar_start;
    logic [TIME_W-1:0]   bar_duration;
    logic signed [1:0]   reversal_dir;

    // register copies held by the tracker, reset values
    logic [SRC_W-1:0]    cfg_src  = SRC_LAST;
    logic [CFG_W-1:0]    cfg_bar  = 16'd1;
    logic [CFG_W-1:0]    cfg_rev  = 16'd1;
    logic [CFG_W-1:0]    cfg_tick = 16'd1;

    // bar tracker state
    logic                bb_have  = 1'b0;
    logic [PRICE_W-1:0]  bb_open  = '0;
    logic [PRICE_W-1:0]  bb_high  = '0;
    logic [PRICE_W-1:0]  bb_low   = '0;
    logic [PRICE_W-1:0]  bb_close = '0;
    logic [SUM_W-1:0]    bb_vol   = '0;
    logic [TIME_W-1:0]   bb_start = '0;
    logic [TIME_W-1:0]   bb_last  = '0;
    logic signed [1:0]   bb_dir   = ARM_NONE;

    snap_t               bar_snaps[$];     // predicted snapshots, oldest first
    drow_t               dir_rows[$];
    int                  err_cnt   = 0;

    // idle controls shared between the stimulus and the result side
    bit                  tx_idle   = 1'b1;
    bit                  rx_idle   = 1'b1;
    int                  hold_asks = 0;
    int                  hold_seen = 0;

    // random price walk and the time floor of the current phase
    longint              walk_px   = 0;
    int                  trend     = 1;
    logic [TIME_W-1:0]   phase_base = '0;

    reversal_range_bar_builder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick_time    (tick_time),
        .last_price   (last_price),
        .mid_price    (mid_price),
        .bid_price    (bid_price),
        .ask_price    (ask_price),
        .tick_volume  (tick_volume),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .new_bar      (new_bar),
        .bar_open     (bar_open),
        .bar_high     (bar_high),
        .bar_low      (bar_low),
        .bar_close    (bar_close),
        .bar_volume   (bar_volume),
        .bar_start    (bar_start),
        .bar_duration (bar_duration),
        .reversal_dir (reversal_dir)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bar tracker
    // ------------------------------------------------------------------------

    // a - b >= k ticks; a move the wrong way never counts
    function automatic bit dist_reached(logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b,
                                        longint unsigned k);
        longint unsigned need;
        if (a < b)
            return 1'b0;
        need = k * longint'(cfg_tick);
        return longint'(a - b) >= need;
    endfunction

    // apply one tick to the tracked bar and return the snapshot it produces
    function automatic snap_t advance_bar(quote_t q);
        logic [PRICE_W-1:0] px;
        bit                 took;
        bit                 fresh;
        bit                 shut;
        longint unsigned    sum;
        snap_t              s;
        case (cfg_src)
            SRC_LAST: px = q.last_price;
            SRC_MID:  px = q.mid_price;
            SRC_BID:  px = q.bid_price;
            default:  px = q.ask_price;
        endcase
        took  = 1'b0;
        fresh = 1'b0;
        shut  = 1'b0;
        if (q.tick_time > bb_last)
        begin
            took = 1'b1;
            if (bb_have)
            begin
                // an armed reversal wins; when it fires nothing else is looked at
                if (bb_dir == ARM_UP)
                    shut = dist_reached(px, bb_low, longint'(cfg_rev) + 1);
                else if (bb_dir == ARM_DOWN)
                    shut = dist_reached(bb_high, px, longint'(cfg_rev) + 1);
                if (!shut)
                begin
                    if (px > bb_high)
                    begin
                        if (dist_reached(px, bb_low, longint'(cfg_bar)))
                            bb_dir = ARM_DOWN;
                        if (dist_reached(px, bb_open, longint'(cfg_bar) + 1))
                            shut = 1'b1;
                    end
                    else if (px < bb_low)
                    begin
                        if (dist_reached(bb_high, px, longint'(cfg_bar)))
                            bb_dir = ARM_UP;
                        if (dist_reached(bb_open, px, longint'(cfg_bar) + 1))
                            shut = 1'b1;
                    end
                end
            end
            // the armed direction survives a close
            if (!bb_have || shut)
            begin
                fresh    = 1'b1;
                bb_have  = 1'b1;
                bb_open  = px;
                bb_high  = px;
                bb_low   = px;
                bb_vol   = '0;
                bb_start = q.tick_time;
            end
            sum = longint'(bb_vol) + longint'(q.tick_volume);
            if (sum > 64'hFFFF_FFFF_FFFF)
                sum = 64'hFFFF_FFFF_FFFF;
            bb_vol = sum[SUM_W-1:0];
            if (px > bb_high)
                bb_high = px;
            if (px < bb_low)
                bb_low = px;
            bb_close = px;
            bb_last  = q.tick_time;
        end
        s = '0;
        s.accepted = took;
        s.new_bar  = fresh;
        if (bb_have)
        begin
            s.bar_open     = bb_open;
            s.bar_high     = bb_high;
            s.bar_low      = bb_low;
            s.bar_close    = bb_close;
            s.bar_volume   = bb_vol;
            s.bar_start    = bb_start;
            s.bar_duration = bb_last - bb_start;
        end
        s.reversal_dir = bb_dir;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // idle lengths: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic quote_t mk_q(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] lp, mp, bp, ap,
                                    logic [VOL_W-1:0] v);
        quote_t q;
        q.tick_time   = t;
        q.last_price  = lp;
        q.mid_price   = mp;
        q.bid_price   = bp;
        q.ask_price   = ap;
        q.tick_volume = v;
        return q;
    endfunction

    function automatic snap_t mk_s(logic acc, logic nb, logic [PRICE_W-1:0] o, h, l, c,
                                   logic [SUM_W-1:0] vol, logic [TIME_W-1:0] st, dur,
                                   logic signed [1:0] dir);
        snap_t s;
        s.accepted     = acc;
        s.new_bar      = nb;
        s.bar_open     = o;
        s.bar_high     = h;
        s.bar_low      = l;
        s.bar_close    = c;
        s.bar_volume   = vol;
        s.bar_start    = st;
        s.bar_duration = dur;
        s.reversal_dir = dir;
        return s;
    endfunction

    function automatic void put_row(quote_t q, logic [SRC_W-1:0] src, logic typed, snap_t want);
        drow_t d;
        d.q     = q;
        d.src   = src;
        d.typed = typed;
        d.want  = want;
        dir_rows.push_back(d);
    endfunction

    function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // one result transfer against the oldest prediction
    function automatic void take_result();
        snap_t w;
        if (bar_snaps.size() == 0)
        begin
            $error("result transfer with no prediction pending");
            err_cnt++;
            return;
        end
        w = bar_snaps.pop_front();
        cmp_field("accepted",     w.accepted,       accepted);
        cmp_field("new_bar",      w.new_bar,        new_bar);
        cmp_field("bar_open",     w.bar_open,       bar_open);
        cmp_field("bar_high",     w.bar_high,       bar_high);
        cmp_field("bar_low",      w.bar_low,        bar_low);
        cmp_field("bar_close",    w.bar_close,      bar_close);
        cmp_field("bar_volume",   w.bar_volume,     bar_volume);
        cmp_field("bar_start",    w.bar_start,      bar_start);
        cmp_field("bar_duration", w.bar_duration,   bar_duration);
        cmp_field("reversal_dir", {w.reversal_dir}, {reversal_dir});
    endfunction

    // random tick: mostly a price walk scaled to the thresholds, some noise
    function automatic quote_t gen_tick();
        quote_t          q;
        logic [63:0]     r;
        logic [TIME_W-1:0] floor_t;
        logic [PRICE_W-1:0] px;
        int              px_unit;
        int unsigned     k;
        longint          step;
        int              pick;
        r = {$urandom, $urandom};
        floor_t = (phase_base > bb_last) ? phase_base : bb_last;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            q.tick_time = r[TIME_W-1:0] % (bb_last + 48'd1);    // stale or repeated
        else if (pick < 9)
            q.tick_time = floor_t + 48'd1 + $urandom;
        else
            q.tick_time = floor_t + $urandom_range(1, 3000);

        px_unit = (cfg_tick == 0) ? $urandom_range(1, 50) : int'(cfg_tick);
        k = $urandom_range(0, int'(cfg_bar) + int'(cfg_rev) + 2);
        if ($urandom_range(0, 3) == 0)
            trend = -trend;
        step = longint'(k) * longint'(px_unit);
        if ($urandom_range(0, 3) == 0)
            step = step + (($urandom_range(0, 1) == 0) ? -1 : 1);   // just off a boundary
        walk_px = walk_px + trend * step;
        if (walk_px < 0)
            walk_px = 0;
        if (walk_px > PX_MAX)
            walk_px = PX_MAX;
        px = ($urandom_range(0, 9) == 0) ? $urandom : walk_px[PRICE_W-1:0];

        q.last_price = $urandom;
        q.mid_price  = $urandom;
        q.bid_price  = $urandom;
        q.ask_price  = $urandom;
        case (cfg_src)
            SRC_LAST: q.last_price = px;
            SRC_MID:  q.mid_price  = px;
            SRC_BID:  q.bid_price  = px;
            default:  q.ask_price  = px;
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 5)
            q.tick_volume = '1;
        else if (pick < 10)
            q.tick_volume = '0;
        else if (pick < 40)
            q.tick_volume = $urandom;
        else
            q.tick_volume = $urandom_range(0, 5000);
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus tasks; all of them run just after a rising edge
    // ------------------------------------------------------------------------

    // present one tick, hold it until the transfer, then record the prediction
    task automatic offer_tick(input quote_t q, input logic typed, input snap_t want,
                              output bit took);
        int    gap;
        snap_t s;
        if (tx_idle && $urandom_range(0, 99) < 30)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        tick_time   <= q.tick_time;
        last_price  <= q.last_price;
        mid_price   <= q.mid_price;
        bid_price   <= q.bid_price;
        ask_price   <= q.ask_price;
        tick_volume <= q.tick_volume;
        do
            @(posedge clk);
        while (in_stall);
        s = advance_bar(q);
        took = s.accepted;
        bar_snaps.push_back(typed ? want : s);
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        while (bar_snaps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_we after its last write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_PRICE_SOURCE:  cfg_src  = data[SRC_W-1:0];
            REG_BAR_SIZE:      cfg_bar  = data;
            REG_REVERSAL_SIZE: cfg_rev  = data;
            default:           cfg_tick = data;
        endcase
    endtask

    task automatic set_cfg(input logic [SRC_W-1:0] src, input logic [CFG_W-1:0] bar_sz,
                           input logic [CFG_W-1:0] rev_sz, input logic [CFG_W-1:0] tick_sz);
        write_reg(REG_PRICE_SOURCE, CFG_W'(src));
        write_reg(REG_BAR_SIZE, bar_sz);
        write_reg(REG_REVERSAL_SIZE, rev_sz);
        write_reg(REG_TICK_SIZE, tick_sz);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks every transfer, then picks next cycle's stall.
    // A hold request from the stimulus side turns into a long stall counted
    // here, so the input queue fills and the block has to stall its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                take_result();
            if (hold_asks != hold_seen)
            begin
                hold_seen  = hold_asks;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_gap() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        quote_t      q;
        logic [63:0] r;
        bit          took;
        int          n_acc;
        int          n_sent;

        // Directed table, reset registers first (source last, sizes of one).
        // Typed rows: nothing before the first bar, the opening tick, a
        // repeated timestamp and an unchanged price.
        put_row(mk_q(0, 100, 200, 300, 400, 3), SRC_LAST, 1'b1,
                mk_s(0, 0, 0, 0, 0, 0, 0, 0, 0, ARM_NONE));
        put_row(mk_q(1, 1000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 7), SRC_LAST, 1'b1,
                mk_s(1, 1, 1000, 1000, 1000, 1000, 7, 1, 0, ARM_NONE));
        put_row(mk_q(1, 3, 0, 0, 0, 9), SRC_LAST, 1'b1,
                mk_s(0, 0, 1000, 1000, 1000, 1000, 7, 1, 0, ARM_NONE));
        put_row(mk_q(2, 1000, 5, 6, 7, 0), SRC_LAST, 1'b1,
                mk_s(1, 0, 1000, 1000, 1000, 1000, 7, 1, 1, ARM_NONE));
        // one tick up arms a drop, then a two-tick drop closes by reversal
        put_row(mk_q(3, 1001, 0, 0, 0, 1), SRC_LAST, 1'b0, '0);
        put_row(mk_q(4, 1000, 0, 0, 0, 2), SRC_LAST, 1'b0, '0);
        put_row(mk_q(5, 999, 0, 0, 0, 3), SRC_LAST, 1'b0, '0);
        // new low arms a rebound, which then closes the bar
        put_row(mk_q(6, 998, 0, 0, 0, 4), SRC_LAST, 1'b0, '0);
        put_row(mk_q(7, 1000, 0, 0, 0, 5), SRC_LAST, 1'b0, '0);
        // a rise past the open, closed by the armed reversal
        put_row(mk_q(8, 1003, 0, 0, 0, 6), SRC_LAST, 1'b0, '0);
        // price and volume extremes
        put_row(mk_q(9, 32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF), SRC_LAST, 1'b0, '0);
        put_row(mk_q(10, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                SRC_LAST, 1'b0, '0);
        put_row(mk_q(11, 0, 1, 2, 3, 32'hFFFF_FFFF), SRC_LAST, 1'b0, '0);
        put_row(mk_q(7, 5, 5, 5, 5, 5), SRC_LAST, 1'b0, '0);
        // the other price sources
        put_row(mk_q(12, 32'hFFFF_FFFF, 5, 0, 32'hFFFF_FFFF, 4), SRC_MID, 1'b0, '0);
        put_row(mk_q(13, 0, 2, 32'hFFFF_FFFF, 0, 4), SRC_MID, 1'b0, '0);
        put_row(mk_q(14, 0, 9, 0, 0, 1), SRC_MID, 1'b0, '0);
        put_row(mk_q(20, 1, 2, 100, 4, 1), SRC_BID, 1'b0, '0);
        put_row(mk_q(21, 1, 2, 97, 4, 1), SRC_BID, 1'b0, '0);
        put_row(mk_q(30, 7, 7, 7, 50, 1), SRC_ASK, 1'b0, '0);
        put_row(mk_q(31, 7, 7, 7, 53, 1), SRC_ASK, 1'b0, '0);
        put_row(mk_q(40, 32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000,
                     32'h0000_FFFF), SRC_LAST, 1'b0, '0);
        put_row(mk_q(40, 1, 2, 3, 4, 5), SRC_LAST, 1'b0, '0);

        // single reset at the start
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            // a source change needs an idle block
            if (dir_rows[i].src != cfg_src)
            begin
                drain_results();
                write_reg(REG_PRICE_SOURCE, CFG_W'(dir_rows[i].src));
                cfg_we <= 1'b0;
            end
            offer_tick(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].want, took);
        end

        // Random phases. Each one starts idle, loads all four registers and
        // raises the time floor so the upper timestamp bits move over the run.
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            case (p)
                0: set_cfg(SRC_LAST, 16'd1, 16'd1, 16'd1);
                1: set_cfg(SRC_MID, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                // zero tick size: every threshold is zero
                2: set_cfg(SRC_BID, CFG_W'($urandom_range(0, 4)),
                           CFG_W'($urandom_range(1, 4)), 16'd0);
                // zero bar and reversal sizes
                3: set_cfg(SRC_ASK, 16'd0, 16'd0, CFG_W'($urandom_range(1, 20)));
                default: set_cfg(SRC_W'($urandom_range(0, 3)), CFG_W'($urandom_range(1, 6)),
                                 CFG_W'($urandom_range(1, 6)),
                                 ($urandom_range(0, 3) == 0)
                                     ? CFG_W'($urandom_range(1, 65535))
                                     : CFG_W'($urandom_range(1, 200)));
            endcase
            r = {$urandom, $urandom};
            phase_base = {p[3:0], 44'd0} | {8'd0, r[39:0]};
            walk_px = $urandom;
            trend = 1;
            if (p == HOLD_PHASE)
                hold_asks++;
            n_acc = 0;
            n_sent = 0;
            while (n_acc < PER_PHASE)
            begin
                // idling is re-chosen in blocks, some blocks run flat out
                if (n_sent % 16 == 0)
                begin
                    tx_idle = (p == HOLD_PHASE && n_sent < 32) ? 1'b0
                                                               : ($urandom_range(0, 9) < 7);
                    rx_idle = ($urandom_range(0, 9) < 7);
                end
                offer_tick(gen_tick(), 1'b0, '0, took);
                n_sent++;
                if (took)
                    n_acc++;
            end
        end

        // Flat bar fed maximum volume, back to back on both sides.
        drain_results();
        set_cfg(SRC_LAST, 16'd1000, 16'd1000, 16'd1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int i = 0; i < FLAT_TICKS; i++)
        begin
            q = mk_q(bb_last + 48'd1, 32'd12345, $urandom, $urandom, $urandom, '1);
            offer_tick(q, 1'b0, '0, took);
        end

        // Largest timestamp, then ticks that can only be stale.
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        offer_tick(mk_q('1, $urandom, $urandom, $urandom, $urandom, $urandom), 1'b0, '0, took);
        for (int i = 0; i < 3; i++)
        begin
            r = {$urandom, $urandom};
            q = mk_q(r[TIME_W-1:0], $urandom, $urandom, $urandom, $urandom, $urandom);
            offer_tick(q, 1'b0, '0, took);
        end

        drain_results();
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
